>>> design/tcca_pkg.sv
// ----------------------------------------------------------------------------
// Touch coordinate calibrate and average: shared package
// Beat types, register codes, field widths and the divider request type.
// ----------------------------------------------------------------------------
package tcca_pkg;

    // Field widths
    localparam int RAW_W      = 16;
    localparam int RAW_SHIFT  = 3;
    localparam int CAL_W      = 13;
    localparam int RES_W      = 12;
    localparam int ORIENT_W   = 3;
    localparam int COORD_W    = 16;
    localparam int PROD_W     = CAL_W + RES_W;
    localparam int SCALED_W   = 15;

    // Shared divider sizes
    localparam int DVD_W      = PROD_W;
    localparam int DVS_W      = CAL_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Default window depth
    localparam int WINDOW_DEPTH_DEF = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN    = 3'd0,
        CFG_X_MAX    = 3'd1,
        CFG_Y_MIN    = 3'd2,
        CFG_Y_MAX    = 3'd3,
        CFG_H_RES    = 3'd4,
        CFG_V_RES    = 3'd5,
        CFG_ORIENT   = 3'd6
    } t_cfg_idx;

    // Orientation bits
    localparam int ORIENT_SWAP  = 0;
    localparam int ORIENT_INV_X = 1;
    localparam int ORIENT_INV_Y = 2;

    // Input beat
    typedef struct packed {
        logic             pressed;
        logic [RAW_W-1:0] raw_x_word;
        logic [RAW_W-1:0] raw_y_word;
    } t_tcca_in;

    // Output beat
    typedef struct packed {
        logic signed [COORD_W-1:0] x_position;
        logic signed [COORD_W-1:0] y_position;
        logic                      touch_valid;
    } t_tcca_out;

    // Request into the shared divider
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_tcca_div_req;

    // Result from the shared divider
    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_tcca_div_rsp;

endpackage

>>> design/tcca_div.sv
// ----------------------------------------------------------------------------
// Touch coordinate calibrate and average: shared divider
// Unsigned restoring divider, one quotient bit per cycle. A start request
// loads the operands; done pulses for one cycle when the quotient is ready.
// The divisor must not be zero.
// ----------------------------------------------------------------------------
module tcca_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tcca_pkg::t_tcca_div_req i_req,
    output tcca_pkg::t_tcca_div_rsp o_rsp
);

    localparam int DW  = tcca_pkg::DVD_W;
    localparam int SW  = tcca_pkg::DVS_W;
    localparam int CW  = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [SW-1:0] r_dvs;

    logic [SW:0]   w_part;
    logic [SW+1:0] w_diff;
    logic          w_qbit;
    logic [SW-1:0] n_rem;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        w_part = {r_rem, r_quo[DW-1]};
        w_diff = {1'b0, w_part} - {2'b00, r_dvs};
        w_qbit = ~w_diff[SW+1];
        n_rem  = w_qbit ? w_diff[SW-1:0] : w_part[SW-1:0];
    end

    // Iteration control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DW-2:0], w_qbit};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> design/touch_coordinate_calibrate_average_core.sv
// ----------------------------------------------------------------------------
// Touch coordinate calibrate and average: top level
// Scales raw touch readings to screen pixels and smooths them over a
// moving-average window, sharing one iterative divider for all divisions.
//
//   Channel | Direction | Handshake                | Beat
//   --------+-----------+--------------------------+----------------------
//   in      | input     | i_in_valid / o_in_ready  | t_tcca_in
//   out     | output    | o_out_valid / i_out_ready| t_tcca_out
//   cfg     | input     | i_cfg_valid / o_cfg_ready| index + data
//
// A pressed sample makes four divisions on the shared divider between one
// input beat and the next (two scalings, two averages), each with a 25-bit
// quotient; an axis with an empty span skips its scaling division. A
// released sample goes straight to the output step. A new sample is taken
// only in the idle state. A finished beat waits in the output register, so
// only a stalled output with a second result ready holds the block. Reset
// is synchronous and active low.
// ----------------------------------------------------------------------------
module touch_coordinate_calibrate_average_core #(
    parameter int WINDOW_DEPTH = tcca_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tcca_pkg::t_tcca_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tcca_pkg::t_tcca_out                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tcca_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcca_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CAL_W    = tcca_pkg::CAL_W;
    localparam int RES_W    = tcca_pkg::RES_W;
    localparam int COORD_W  = tcca_pkg::COORD_W;
    localparam int PROD_W   = tcca_pkg::PROD_W;
    localparam int SCALED_W = tcca_pkg::SCALED_W;
    localparam int DVD_W    = tcca_pkg::DVD_W;
    localparam int DVS_W    = tcca_pkg::DVS_W;
    localparam int CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W    = COORD_W + CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CAL,
        S_CAL_WAIT,
        S_INV,
        S_PUSH,
        S_AVG,
        S_AVG_WAIT,
        S_DONE
    } t_state;

    // Configuration registers
    logic [CAL_W-1:0]              r_x_min, r_x_max, r_y_min, r_y_max;
    logic [RES_W-1:0]              r_h_res, r_v_res;
    logic [tcca_pkg::ORIENT_W-1:0] r_orient;

    // Sequencer and datapath registers
    t_state                      r_state;
    logic                        r_axis;
    logic                        r_pressed;
    logic [CAL_W-1:0]            r_a, r_b;
    logic [PROD_W-1:0]           r_prod;
    logic [DVS_W-1:0]            r_span;
    logic                        r_span_ok;
    logic [SCALED_W-1:0]         r_scaled;
    logic signed [COORD_W-1:0]   r_cal_x, r_cal_y;
    logic signed [COORD_W-1:0]   r_win_x [WINDOW_DEPTH];
    logic signed [COORD_W-1:0]   r_win_y [WINDOW_DEPTH];
    logic [CNT_W-1:0]            r_fill;
    logic signed [SUM_W-1:0]     r_sum_x, r_sum_y;
    logic signed [COORD_W-1:0]   r_held_x, r_held_y;
    logic                        r_out_valid;
    tcca_pkg::t_tcca_out         r_out;

    // Combinational helpers
    logic [CAL_W-1:0]            w_val, w_lo, w_hi;
    logic [RES_W-1:0]            w_res;
    logic                        w_inv;
    logic [CAL_W-1:0]            w_off;
    logic [PROD_W-1:0]           w_prod;
    logic [SCALED_W-1:0]         w_sat;
    logic signed [COORD_W-1:0]   w_cal;
    logic                        w_full;
    logic signed [SUM_W-1:0]     w_drop_x, w_drop_y;
    logic signed [SUM_W-1:0]     w_sum;
    logic                        w_neg;
    logic [SUM_W-1:0]            w_mag;
    logic [COORD_W-1:0]          w_qlow;
    logic signed [COORD_W-1:0]   w_mean;
    logic [CAL_W-1:0]            w_raw_x, w_raw_y;
    tcca_pkg::t_tcca_div_req     w_div_req;
    tcca_pkg::t_tcca_div_rsp     w_div_rsp;

    // Shared divider
    tcca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Raw words reduced to converter resolution.
    assign w_raw_x = CAL_W'(i_in_data.raw_x_word >> tcca_pkg::RAW_SHIFT);
    assign w_raw_y = CAL_W'(i_in_data.raw_y_word >> tcca_pkg::RAW_SHIFT);

    // Per-axis operand selection, offset and product.
    always_comb begin
        w_val  = r_axis ? r_b : r_a;
        w_lo   = r_axis ? r_y_min : r_x_min;
        w_hi   = r_axis ? r_y_max : r_x_max;
        w_res  = r_axis ? r_v_res : r_h_res;
        w_inv  = r_axis ? r_orient[tcca_pkg::ORIENT_INV_Y]
                        : r_orient[tcca_pkg::ORIENT_INV_X];
        w_off  = (w_val > w_lo) ? (w_val - w_lo) : '0;
        w_prod = PROD_W'(w_off) * PROD_W'(w_res);
    end

    // Saturation of the scaled value and optional inversion.
    always_comb begin
        w_sat = (|w_div_rsp.quotient[DVD_W-1:SCALED_W]) ? '1
                                                         : w_div_rsp.quotient[SCALED_W-1:0];
        w_cal = w_inv ? (COORD_W'(w_res) - COORD_W'(r_scaled)) : COORD_W'(r_scaled);
    end

    // Window update terms: the oldest entry leaves once the window is full.
    always_comb begin
        w_full   = (r_fill == CNT_W'(WINDOW_DEPTH));
        w_drop_x = w_full ? {{(SUM_W-COORD_W){r_win_x[WINDOW_DEPTH-1][COORD_W-1]}},
                             r_win_x[WINDOW_DEPTH-1]} : '0;
        w_drop_y = w_full ? {{(SUM_W-COORD_W){r_win_y[WINDOW_DEPTH-1][COORD_W-1]}},
                             r_win_y[WINDOW_DEPTH-1]} : '0;
    end

    // Signed mean: divide the magnitude, then restore the sign.
    always_comb begin
        w_sum  = r_axis ? r_sum_y : r_sum_x;
        w_neg  = w_sum[SUM_W-1];
        w_mag  = w_neg ? (~w_sum + SUM_W'(1)) : w_sum;
        w_qlow = w_div_rsp.quotient[COORD_W-1:0];
        w_mean = w_neg ? (~w_qlow + COORD_W'(1)) : w_qlow;
    end

    // Divider requests for scaling and for averaging.
    always_comb begin
        w_div_req.start    = ((r_state == S_CAL) && r_span_ok) || (r_state == S_AVG);
        w_div_req.dividend = (r_state == S_AVG) ? DVD_W'(w_mag) : r_prod;
        w_div_req.divisor  = (r_state == S_AVG) ? DVS_W'(r_fill) : r_span;
    end

    // Configuration writes are always taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min  <= '0;
            r_x_max  <= '1;
            r_y_min  <= '0;
            r_y_max  <= '1;
            r_h_res  <= RES_W'(320);
            r_v_res  <= RES_W'(240);
            r_orient <= '0;
        end else if (i_cfg_valid) begin
            case (tcca_pkg::t_cfg_idx'(i_cfg_index))
                tcca_pkg::CFG_X_MIN:  r_x_min  <= i_cfg_data[CAL_W-1:0];
                tcca_pkg::CFG_X_MAX:  r_x_max  <= i_cfg_data[CAL_W-1:0];
                tcca_pkg::CFG_Y_MIN:  r_y_min  <= i_cfg_data[CAL_W-1:0];
                tcca_pkg::CFG_Y_MAX:  r_y_max  <= i_cfg_data[CAL_W-1:0];
                tcca_pkg::CFG_H_RES:  r_h_res  <= i_cfg_data[RES_W-1:0];
                tcca_pkg::CFG_V_RES:  r_v_res  <= i_cfg_data[RES_W-1:0];
                tcca_pkg::CFG_ORIENT: r_orient <= i_cfg_data[tcca_pkg::ORIENT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer with its datapath and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_pressed   <= 1'b0;
            r_fill      <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pressed <= i_in_data.pressed;
                        r_axis    <= 1'b0;
                        if (r_orient[tcca_pkg::ORIENT_SWAP]) begin
                            r_a <= w_raw_y;
                            r_b <= w_raw_x;
                        end else begin
                            r_a <= w_raw_x;
                            r_b <= w_raw_y;
                        end
                        if (i_in_data.pressed) begin
                            r_state <= S_MUL;
                        end else begin
                            r_fill  <= '0;
                            r_sum_x <= '0;
                            r_sum_y <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    r_prod    <= w_prod;
                    r_span    <= w_hi - w_lo;
                    r_span_ok <= (w_hi > w_lo);
                    r_state   <= S_CAL;
                end
                S_CAL: begin
                    if (r_span_ok) begin
                        r_state <= S_CAL_WAIT;
                    end else begin
                        r_scaled <= '0;
                        r_state  <= S_INV;
                    end
                end
                S_CAL_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_scaled <= w_sat;
                        r_state  <= S_INV;
                    end
                end
                S_INV: begin
                    if (r_axis) begin
                        r_cal_y <= w_cal;
                        r_axis  <= 1'b0;
                        r_state <= S_PUSH;
                    end else begin
                        r_cal_x <= w_cal;
                        r_axis  <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_PUSH: begin
                    for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
                        r_win_x[i] <= r_win_x[i-1];
                        r_win_y[i] <= r_win_y[i-1];
                    end
                    r_win_x[0] <= r_cal_x;
                    r_win_y[0] <= r_cal_y;
                    r_sum_x <= r_sum_x + {{(SUM_W-COORD_W){r_cal_x[COORD_W-1]}}, r_cal_x}
                               - w_drop_x;
                    r_sum_y <= r_sum_y + {{(SUM_W-COORD_W){r_cal_y[COORD_W-1]}}, r_cal_y}
                               - w_drop_y;
                    if (!w_full) begin
                        r_fill <= r_fill + CNT_W'(1);
                    end
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_state <= S_AVG_WAIT;
                end
                S_AVG_WAIT: begin
                    if (w_div_rsp.done) begin
                        if (r_axis) begin
                            r_held_y <= w_mean;
                            r_axis   <= 1'b0;
                            r_state  <= S_DONE;
                        end else begin
                            r_held_x <= w_mean;
                            r_axis   <= 1'b1;
                            r_state  <= S_AVG;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.x_position  <= r_held_x;
                        r_out.y_position  <= r_held_y;
                        r_out.touch_valid <= r_pressed;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // The fill count never passes the window depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count above window depth");

    // An empty window carries zero running sums.
    a_empty_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_sum_x == '0 && r_sum_y == '0))
        else $error("running sum nonzero with empty window");

    // A release beat empties the window.
    a_release_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in_data.pressed) |=> (r_fill == '0))
        else $error("window not emptied on release");

    // A new output beat is loaded only from the final sequencer step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output beat raised outside the final step");

endmodule

>>> verif/touch_coordinate_calibrate_average_core_test.sv
// ----------------------------------------------------------------------------
// Touch coordinate calibrate and average: block-level test
// Drives touch samples and register writes into the core under random
// idling on both channels. A scoreboard class predicts every output beat
// (calibrated, scaled and window-averaged position, or the held position on
// release) and compares it field by field with what the core delivers.
// ----------------------------------------------------------------------------
module touch_coordinate_calibrate_average_core_test;

    localparam int DEPTH        = tcca_pkg::WINDOW_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int SETTLE_TICKS = 8;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 140;

    // Scoreboard: predicts the position beat for every accepted sample.
    class touch_position_checker;
        int                             cal [tcca_pkg::CFG_ORIENT+1];
        int                             win_x [DEPTH];
        int                             win_y [DEPTH];
        int                             fill;
        logic [tcca_pkg::COORD_W-1:0]   held_x;
        logic [tcca_pkg::COORD_W-1:0]   held_y;
        tcca_pkg::t_tcca_out            expected_positions [$];
        int                             errors;
        int                             checked;
        int                             presses;
        int                             releases;

        function new();
            cal[tcca_pkg::CFG_X_MIN]  = 0;
            cal[tcca_pkg::CFG_X_MAX]  = 8191;
            cal[tcca_pkg::CFG_Y_MIN]  = 0;
            cal[tcca_pkg::CFG_Y_MAX]  = 8191;
            cal[tcca_pkg::CFG_H_RES]  = 320;
            cal[tcca_pkg::CFG_V_RES]  = 240;
            cal[tcca_pkg::CFG_ORIENT] = 0;
            fill     = 0;
            held_x   = '0;
            held_y   = '0;
            errors   = 0;
            checked  = 0;
            presses  = 0;
            releases = 0;
        endfunction

        function void write_register(tcca_pkg::t_cfg_idx idx,
                                     logic [tcca_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tcca_pkg::CFG_H_RES, tcca_pkg::CFG_V_RES: begin
                    cal[idx] = int'(data[tcca_pkg::RES_W-1:0]);
                end
                tcca_pkg::CFG_ORIENT: begin
                    cal[idx] = int'(data[tcca_pkg::ORIENT_W-1:0]);
                end
                default: begin
                    cal[idx] = int'(data[tcca_pkg::CAL_W-1:0]);
                end
            endcase
        endfunction

        // Offset from the minimum, scaled by resolution over span, saturated,
        // then optionally mirrored against the resolution.
        function int scale_axis(int raw, int lo, int hi, int res, bit invert);
            int off;
            int scaled;
            off    = (raw > lo) ? raw - lo : 0;
            scaled = 0;
            if (hi > lo) begin
                scaled = (off * res) / (hi - lo);
                if (scaled > 32767) scaled = 32767;
            end
            return invert ? res - scaled : scaled;
        endfunction

        function void take_sample(tcca_pkg::t_tcca_in s);
            tcca_pkg::t_tcca_out want;
            int        a;
            int        b;
            int        t;
            int        sum_x;
            int        sum_y;
            if (!s.pressed) begin
                // Release empties the window and repeats the last position.
                fill = 0;
                releases++;
                want.touch_valid = 1'b0;
            end else begin
                presses++;
                a = int'(s.raw_x_word >> tcca_pkg::RAW_SHIFT);
                b = int'(s.raw_y_word >> tcca_pkg::RAW_SHIFT);
                if (cal[tcca_pkg::CFG_ORIENT][tcca_pkg::ORIENT_SWAP]) begin
                    t = a;
                    a = b;
                    b = t;
                end
                for (int i = DEPTH - 1; i > 0; i--) begin
                    win_x[i] = win_x[i-1];
                    win_y[i] = win_y[i-1];
                end
                win_x[0] = scale_axis(a, cal[tcca_pkg::CFG_X_MIN], cal[tcca_pkg::CFG_X_MAX],
                                      cal[tcca_pkg::CFG_H_RES],
                                      cal[tcca_pkg::CFG_ORIENT][tcca_pkg::ORIENT_INV_X]);
                win_y[0] = scale_axis(b, cal[tcca_pkg::CFG_Y_MIN], cal[tcca_pkg::CFG_Y_MAX],
                                      cal[tcca_pkg::CFG_V_RES],
                                      cal[tcca_pkg::CFG_ORIENT][tcca_pkg::ORIENT_INV_Y]);
                if (fill < DEPTH) fill++;
                sum_x = 0;
                sum_y = 0;
                for (int i = 0; i < fill; i++) begin
                    sum_x += win_x[i];
                    sum_y += win_y[i];
                end
                // Signed division truncates toward zero.
                held_x = 16'(sum_x / fill);
                held_y = 16'(sum_y / fill);
                want.touch_valid = 1'b1;
            end
            want.x_position = held_x;
            want.y_position = held_y;
            expected_positions.push_back(want);
        endfunction

        function void check_position(tcca_pkg::t_tcca_out got);
            tcca_pkg::t_tcca_out want;
            if (expected_positions.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat x=%0d y=%0d valid=%0b", $time,
                         got.x_position, got.y_position, got.touch_valid);
                return;
            end
            want = expected_positions.pop_front();
            checked++;
            if (got.x_position !== want.x_position) begin
                errors++;
                $display("%0t: x_position expected %0d actual %0d", $time,
                         want.x_position, got.x_position);
            end
            if (got.y_position !== want.y_position) begin
                errors++;
                $display("%0t: y_position expected %0d actual %0d", $time,
                         want.y_position, got.y_position);
            end
            if (got.touch_valid !== want.touch_valid) begin
                errors++;
                $display("%0t: touch_valid expected %0b actual %0b", $time,
                         want.touch_valid, got.touch_valid);
            end
        endfunction

        function int pending();
            return expected_positions.size();
        endfunction
    endclass

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            in_valid   = 1'b0;
    logic                            in_ready;
    tcca_pkg::t_tcca_in              in_data    = '0;
    logic                            out_valid;
    logic                            out_ready  = 1'b0;
    tcca_pkg::t_tcca_out             out_data;
    logic                            cfg_valid  = 1'b0;
    logic                            cfg_ready;
    logic [tcca_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [tcca_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    touch_position_checker sb = new();
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    cycles        = 0;
    int                    settings      = 0;

    touch_coordinate_calibrate_average_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver stalls at random with the current idle rate.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watch all three channels with the values the core saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready) begin
                sb.write_register(tcca_pkg::t_cfg_idx'(cfg_index), cfg_data);
            end
            if (in_valid && in_ready) sb.take_sample(in_data);
            if (out_valid && out_ready) sb.check_position(out_data);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("touch_coordinate_calibrate_average_core_test: errors");
            $finish;
        end
    end

    task automatic send_sample(input tcca_pkg::t_tcca_in s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Stop sending and wait for every predicted beat to come back. The first
    // edge lets the scoreboard note a beat accepted at the previous edge.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input tcca_pkg::t_cfg_idx idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[tcca_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_calibration(input int xmin, input int xmax, input int ymin,
                                   input int ymax, input int hres, input int vres,
                                   input int orient);
        settle();
        write_reg(tcca_pkg::CFG_X_MIN, xmin);
        write_reg(tcca_pkg::CFG_X_MAX, xmax);
        write_reg(tcca_pkg::CFG_Y_MIN, ymin);
        write_reg(tcca_pkg::CFG_Y_MAX, ymax);
        write_reg(tcca_pkg::CFG_H_RES, hres);
        write_reg(tcca_pkg::CFG_V_RES, vres);
        write_reg(tcca_pkg::CFG_ORIENT, orient);
        settings++;
    endtask

    task automatic send_touch(input bit pressed, input int x, input int y);
        tcca_pkg::t_tcca_in s;
        s.pressed    = pressed;
        s.raw_x_word = x[tcca_pkg::RAW_W-1:0];
        s.raw_y_word = y[tcca_pkg::RAW_W-1:0];
        send_sample(s);
    endtask

    // Converter word that mostly lands inside the calibrated span of an axis.
    function automatic logic [tcca_pkg::RAW_W-1:0] axis_word(input int lo, input int hi);
        int r;
        int v;
        r = $urandom_range(99);
        if (r >= 88) return tcca_pkg::RAW_W'($urandom_range(65535));
        if (r < 75) begin
            v = (lo < hi) ? $urandom_range(hi, lo) : $urandom_range(lo, hi);
        end else begin
            case ($urandom_range(3))
                0: v = 0;
                1: v = 8191;
                2: v = lo;
                default: v = hi;
            endcase
        end
        return tcca_pkg::RAW_W'((v << tcca_pkg::RAW_SHIFT) | $urandom_range(7));
    endfunction

    function automatic tcca_pkg::t_tcca_in shaped_touch(input bit pressed);
        tcca_pkg::t_tcca_in          s;
        logic [tcca_pkg::RAW_W-1:0]  wx;
        logic [tcca_pkg::RAW_W-1:0]  wy;
        wx = axis_word(sb.cal[tcca_pkg::CFG_X_MIN], sb.cal[tcca_pkg::CFG_X_MAX]);
        wy = axis_word(sb.cal[tcca_pkg::CFG_Y_MIN], sb.cal[tcca_pkg::CFG_Y_MAX]);
        s.pressed = pressed;
        // With swapped axes the x word feeds the y calibration.
        if (sb.cal[tcca_pkg::CFG_ORIENT][tcca_pkg::ORIENT_SWAP]) begin
            s.raw_x_word = wy;
            s.raw_y_word = wx;
        end else begin
            s.raw_x_word = wx;
            s.raw_y_word = wy;
        end
        return s;
    endfunction

    task automatic random_calibration();
        int xmin;
        int xmax;
        int ymin;
        int ymax;
        int hres;
        int vres;
        xmin = $urandom_range(4000);
        xmax = ($urandom_range(99) < 8) ? $urandom_range(xmin) : $urandom_range(8191, xmin + 1);
        ymin = $urandom_range(4000);
        ymax = ($urandom_range(99) < 8) ? $urandom_range(ymin) : $urandom_range(8191, ymin + 1);
        hres = ($urandom_range(99) < 15) ? 4095 : $urandom_range(4095, 1);
        vres = ($urandom_range(99) < 15) ? 1 : $urandom_range(4095, 1);
        set_calibration(xmin, xmax, ymin, ymax, hres, vres, $urandom_range(7));
    endtask

    initial begin
        int  sent;
        int  len;
        bit  paused;

        // Reset.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default calibration: release before any press, raw extremes,
        // low bits dropped by the shift, and a window that overflows.
        send_idle_pct = 26;
        recv_idle_pct = 45;
        send_touch(1'b0, 16'h1234, 16'h4321);
        send_touch(1'b1, 16'h0000, 16'h0000);
        send_touch(1'b1, 16'hFFFF, 16'hFFFF);
        send_touch(1'b1, 16'h0007, 16'hFFF8);
        send_touch(1'b1, 16'hAAAA, 16'h5555);
        send_touch(1'b1, 16'h5555, 16'hAAAA);
        send_touch(1'b1, 16'h8000, 16'h7FFF);
        send_touch(1'b0, 16'hFFFF, 16'hFFFF);
        send_touch(1'b0, 16'h0000, 16'h0000);

        // Negative and empty spans, all orientation bits set.
        set_calibration(8191, 0, 4000, 4000, 4095, 4095, 7);
        send_touch(1'b1, 16'hFFFF, 16'h0000);
        send_touch(1'b1, 16'h1234, 16'hFEDC);
        send_touch(1'b0, 16'h0000, 16'hFFFF);

        // One-count span saturates; inverted x goes negative.
        set_calibration(0, 1, 0, 1, 4095, 1, 2);
        send_touch(1'b1, 16'hFFFF, 16'hFFFF);
        send_touch(1'b1, 16'h0008, 16'h0008);
        send_touch(1'b1, 16'h0000, 16'h0000);
        send_touch(1'b0, 16'h0000, 16'h0000);

        // Zero resolution with both axes inverted.
        set_calibration(0, 8191, 0, 8191, 0, 0, 6);
        send_touch(1'b1, 16'hFFFF, 16'h8000);
        send_touch(1'b0, 16'h0000, 16'h0000);

        // Swapped axes with an ordinary calibration.
        set_calibration(100, 8000, 100, 8000, 320, 240, 1);
        send_touch(1'b1, 16'h0320, 16'hFA00);
        send_touch(1'b1, 16'h1000, 16'h2000);
        send_touch(1'b1, 16'hF000, 16'h0100);
        send_touch(1'b1, 16'h8000, 16'h8000);
        send_touch(1'b0, 16'h0000, 16'h0000);

        // Random phases: press bursts closed by a release, plus some noise.
        paused = 1'b0;
        for (int phase = 0; phase < PHASES; phase++) begin
            random_calibration();
            if (phase < 4) begin
                send_idle_pct = 26;
                recv_idle_pct = 45;
            end else if (phase < 8) begin
                send_idle_pct = 45;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 10) begin
                    send_touch($urandom_range(1), $urandom_range(65535),
                               $urandom_range(65535));
                    sent++;
                end else begin
                    len = $urandom_range(12, 1);
                    repeat (len) send_sample(shaped_touch(1'b1));
                    send_sample(shaped_touch(1'b0));
                    sent += len + 1;
                end
                // Let the core run dry once in the middle of a phase.
                if (phase == 5 && !paused && sent >= PHASE_ITEMS / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        if (sb.pending() != 0) sb.errors++;
        $display("Covered %0d pressed and %0d released samples over %0d calibrations,",
                 sb.presses, sb.releases, settings);
        $display("with %0d position beats checked and %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("touch_coordinate_calibrate_average_core_test: clean");
        end else begin
            $display("touch_coordinate_calibrate_average_core_test: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
design/tcca_pkg.sv
design/tcca_div.sv
design/touch_coordinate_calibrate_average_core.sv
verif/touch_coordinate_calibrate_average_core_test.sv
